@@ hw/rtl/wsh64_pkg.sv @@
// Constants shared by the word stream string hash block.
`default_nettype none
package wsh64_pkg;

    localparam logic [63:0] C_HASH_SEED  = 64'h0000_0000_0000_DEAD;
    localparam logic [63:0] C_WORD_MUL_A = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] C_WORD_MUL_B = 64'h94d0_49bb_1331_11eb;
    localparam logic [63:0] C_FMIX_MUL_A = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] C_FMIX_MUL_B = 64'hc4ce_b9fe_1a85_ec53;
    localparam int unsigned C_WORD_SHIFT = 24;
    localparam int unsigned C_FMIX_SHIFT = 33;
    localparam logic [3:0]  C_FULL_COUNT = 4'd8;

    typedef enum logic [1:0] {
        PH_LO_LO = 2'd0,
        PH_LO_HI = 2'd1,
        PH_HI_LO = 2'd2
    } t_mul_phase;

endpackage
`default_nettype wire

@@ hw/rtl/word_stream_string_hash64_top.sv @@
// Top level of the word stream string hash: sequencer around one shared 32x32 multiplier.
//
//  channel | dir | handshake              | payload
//  s       | in  | i_s_tvalid/o_s_tready  | tdata {pad, byte_count, data_word}, tlast = last
//  m       | out | o_m_tvalid/i_m_tready  | tdata hash_value, tuser error
//
// Each 64-bit multiply takes three passes through the one 32x32 multiplier.
// A full non-last word passes through accept, 3 multiplies and 1 shift-xor.
// A last item adds the finalizer: 3 shift-xors and 2 multiplies.
// A short non-last item sets the error flag and leaves the hash unchanged. Reset is synchronous, active low.
// The result waits in an output register; the finalizer holds only if it is still full.
`default_nettype none
module word_stream_string_hash64_top
    import wsh64_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,   // [63:0] data_word, [67:64] byte_count, [71:68] zero
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // [63:0] hash_value
    output logic             o_m_tuser    // [0] error
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_W_MA,
        S_W_SH,
        S_W_MB,
        S_H_MFA,
        S_T_MFB,
        S_F_SH1,
        S_F_MA,
        S_F_SH2,
        S_F_MB,
        S_F_SH3
    } t_state;

    t_state      r_state;
    t_mul_phase  r_phase;
    logic [63:0] r_h;
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic        r_bad;
    logic        r_last;
    logic [2:0]  r_count7;
    logic        r_m_valid;
    logic [63:0] r_m_hash;
    logic        r_m_err;

    logic [63:0] in_word;
    logic [3:0]  in_cnt_raw;
    logic [3:0]  in_cnt;
    logic [63:0] tail_mask;
    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_prod;
    logic [63:0] mul_res;
    logic        in_accept;

    assign in_word    = i_s_tdata[63:0];
    assign in_cnt_raw = i_s_tdata[67:64];
    assign in_cnt     = (in_cnt_raw > C_FULL_COUNT) ? C_FULL_COUNT : in_cnt_raw;
    assign tail_mask  = (64'd1 << {in_cnt[2:0], 3'b000}) - 64'd1;
    assign o_s_tready = (r_state == S_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_hash;
    assign o_m_tuser  = r_m_err;

    always_comb begin
        unique case (r_state)
            S_W_MA:  mul_const = C_WORD_MUL_A;
            S_W_MB:  mul_const = C_WORD_MUL_B;
            S_H_MFA: mul_const = C_FMIX_MUL_A;
            S_F_MA:  mul_const = C_FMIX_MUL_A;
            default: mul_const = C_FMIX_MUL_B;
        endcase
    end

    always_comb begin
        unique case (r_phase)
            PH_LO_LO: begin
                mul_a = r_x[31:0];
                mul_b = mul_const[31:0];
            end
            PH_LO_HI: begin
                mul_a = r_x[31:0];
                mul_b = mul_const[63:32];
            end
            default: begin
                mul_a = r_x[63:32];
                mul_b = mul_const[31:0];
            end
        endcase
    end

    assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};
    assign mul_res  = r_acc + {mul_prod[31:0], 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_LO_LO;
            r_h       <= C_HASH_SEED;
            r_bad     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready && r_state != S_F_SH3) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_last   <= i_s_tlast;
                        r_count7 <= in_cnt[2:0];
                        r_phase  <= PH_LO_LO;
                        if (in_cnt == C_FULL_COUNT) begin
                            r_x     <= in_word;
                            r_state <= S_W_MA;
                        end else if (!i_s_tlast) begin
                            r_bad <= 1'b1;
                        end else if (in_cnt == 4'd0) begin
                            r_x     <= r_h;
                            r_state <= S_F_SH1;
                        end else begin
                            r_x     <= r_h ^ (in_word & tail_mask);
                            r_state <= S_T_MFB;
                        end
                    end
                end
                S_W_MA, S_W_MB, S_H_MFA, S_T_MFB, S_F_MA, S_F_MB: begin
                    unique case (r_phase)
                        PH_LO_LO: begin
                            r_acc   <= mul_prod;
                            r_phase <= PH_LO_HI;
                        end
                        PH_LO_HI: begin
                            r_acc   <= mul_res;
                            r_phase <= PH_HI_LO;
                        end
                        default: begin
                            r_phase <= PH_LO_LO;
                            unique case (r_state)
                                S_W_MA: begin
                                    r_x     <= mul_res;
                                    r_state <= S_W_SH;
                                end
                                S_W_MB: begin
                                    r_x     <= r_h ^ mul_res;
                                    r_state <= S_H_MFA;
                                end
                                S_H_MFA, S_T_MFB: begin
                                    if (r_last) begin
                                        r_x     <= mul_res ^ {61'd0, r_count7};
                                        r_state <= S_F_SH1;
                                    end else begin
                                        r_h     <= mul_res;
                                        r_state <= S_IDLE;
                                    end
                                end
                                S_F_MA: begin
                                    r_x     <= mul_res;
                                    r_state <= S_F_SH2;
                                end
                                default: begin
                                    r_x     <= mul_res;
                                    r_state <= S_F_SH3;
                                end
                            endcase
                        end
                    endcase
                end
                S_W_SH: begin
                    r_x     <= r_x ^ (r_x >> C_WORD_SHIFT);
                    r_state <= S_W_MB;
                end
                S_F_SH1: begin
                    r_x     <= r_x ^ (r_x >> C_FMIX_SHIFT);
                    r_state <= S_F_MA;
                end
                S_F_SH2: begin
                    r_x     <= r_x ^ (r_x >> C_FMIX_SHIFT);
                    r_state <= S_F_MB;
                end
                default: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_hash  <= r_x ^ (r_x >> C_FMIX_SHIFT);
                        r_m_err   <= r_bad;
                        r_h       <= C_HASH_SEED;
                        r_bad     <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire
